// File: hdl/fpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame performance monitor package
// Event opcodes, configuration register indexes and fixed field widths shared
// by the monitor.
// ----------------------------------------------------------------------------
package fpm_pkg;

  // Event codes carried on the opcode field.
  typedef enum logic [2:0] {
    OP_FRAME_BEGIN  = 3'd0,
    OP_SPRITE_SPAN  = 3'd1,
    OP_FRAME_END    = 3'd2,
    OP_EFFECT_START = 3'd3,
    OP_EFFECT_END   = 3'd4
  } op_t;

  // Configuration register indexes.
  localparam logic REG_BUDGET_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW_TARGET    = 1'b1;

  // Widths fixed by the field definitions.
  localparam int CFG_DATA_W  = 16;
  localparam int LINE_CNT_W  = 8;
  localparam int SAMPLE_W    = 9;

  // Line occupancy saturates here.
  localparam logic [LINE_CNT_W-1:0] LINE_CNT_MAX = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [15:0]         BUDGET_RESET = 16'd100;
  localparam logic [SAMPLE_W-1:0] WINDOW_RESET = 9'd256;

endpackage : fpm_pkg
`default_nettype wire

// File: hdl/frame_performance_monitor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame performance monitor
// Per-frame occupancy, effect and processor load statistics driven by events.
// ----------------------------------------------------------------------------
// Usage. An event beat is taken at a rising edge where start is high and busy
// is low; the opcode picks frame begin, sprite span, frame end, effect start
// or effect end, and unused opcodes simply return the current statistics.
// Every event yields exactly one snapshot: done is high for one cycle and the
// statistic ports hold the values after the event during that cycle. The
// statistic ports are the state registers themselves, so they also show the
// live values between beats. The receiver has no way to stall the result.
//
// Timing. Frame end, effect start, effect end and unused opcodes are handled
// in idle: done follows in the cycle after the accepting edge and busy stays
// low, so a new event may be accepted while done is high. A sprite span walks
// its clipped lines through the line occupancy memory, one read-modify-write
// per line in a two-stage pipeline, busy until the last write-back; a span
// with no visible lines is answered from idle. Frame begin sweeps the memory
// to zero, one line a cycle, and reports when the last line is written.
//
// Reset. After rst the same sweep runs with busy high and no result;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module frame_performance_monitor_top
  import fpm_pkg::*;
#(
  parameter int LINE_COUNT      = 256,
  parameter int SAMPLE_CAPACITY = 256,
  parameter int EFFECT_SLOTS    = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration write port.
  input  wire logic                         wr_en,
  input  wire logic                         wr_index,
  input  wire logic [CFG_DATA_W-1:0]        wr_data,
  // Event channel.
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [2:0]                   opcode,
  input  wire logic signed [10:0]           span_top,
  input  wire logic [7:0]                   span_height,
  input  wire logic [6:0]                   effect_id,
  input  wire logic [15:0]                  cpu_load,
  // Result channel.
  output      logic                         done,
  output      logic [6:0]                   active_effects,
  output      logic [6:0]                   effect_peak,
  output      logic [LINE_CNT_W-1:0]        frame_line_peak,
  output      logic [LINE_CNT_W-1:0]        max_line_occupancy,
  output      logic [15:0]                  frames_seen,
  output      logic [SAMPLE_W-1:0]          samples_recorded,
  output      logic                         window_complete,
  output      logic [31:0]                  load_sum,
  output      logic [15:0]                  load_max,
  output      logic [15:0]                  jitter_max,
  output      logic [15:0]                  over_budget_frames
);

  // Address width of the line memory, and counter widths that follow from
  // the parameters.
  localparam int AW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int EW = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
  localparam int SW = ($clog2(SAMPLE_CAPACITY + 1) > SAMPLE_W) ?
                      $clog2(SAMPLE_CAPACITY + 1) : SAMPLE_W;

  localparam logic signed [11:0] LINE_S   = 12'(LINE_COUNT);
  localparam logic [AW-1:0]      LAST_LINE = AW'(LINE_COUNT - 1);
  localparam logic [SW-1:0]      SAMPLE_CAP = SW'(SAMPLE_CAPACITY);
  localparam logic [6:0]         SLOTS     = 7'(EFFECT_SLOTS);

  // Sequencer states. Idle handles every event that needs no memory walk itself;
  // the clear state sweeps the memory, the span state issues one line read per
  // cycle and the drain state retires the last write-back of a span.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_SPAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0]         budget_threshold;
  logic [SAMPLE_W-1:0] window_target;

  // Statistics.
  logic [EFFECT_SLOTS-1:0] effect_mask;
  logic [6:0]              effect_count;
  logic [6:0]              effect_count_peak;
  logic [LINE_CNT_W-1:0]   frame_peak;
  logic [LINE_CNT_W-1:0]   line_peak_max;
  logic [15:0]             frame_counter;
  logic [SW-1:0]           sample_cnt;
  logic                    window_flag;
  logic [31:0]             load_total;
  logic [15:0]             load_peak;
  logic [15:0]             previous_load;
  logic [15:0]             jitter_peak;
  logic [15:0]             over_budget_count;

  // Walk control and the read-modify-write pipeline.
  logic [AW-1:0]         walk_addr;
  logic [AW-1:0]         span_end;
  logic                  clear_report;
  logic                  pipe_vld;
  logic [AW-1:0]         pipe_addr;
  logic [LINE_CNT_W-1:0] rd_data;

  // Line occupancy memory.
  logic [LINE_CNT_W-1:0] line_mem [LINE_COUNT];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [LINE_CNT_W-1:0] mem_wdata;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Span decode: clip the signed span to the line range.
  logic signed [11:0] top_s;
  logic signed [11:0] end_s;
  logic signed [11:0] first_s;
  logic signed [11:0] last_s;
  logic signed [11:0] last_m1;
  logic               span_none;

  always_comb begin
    top_s     = {span_top[10], span_top};
    end_s     = top_s + $signed({4'b0000, span_height});
    span_none = (span_height == 8'd0) || (end_s <= 12'sd0) || (top_s >= LINE_S);
    first_s   = (top_s < 12'sd0) ? 12'sd0 : top_s;
    last_s    = (end_s > LINE_S) ? LINE_S : end_s;
    last_m1   = last_s - 12'sd1;
  end

  // Saturating increment of the line just read.
  logic [LINE_CNT_W-1:0] wb_count;
  assign wb_count = (rd_data == LINE_CNT_MAX) ? LINE_CNT_MAX : rd_data + 8'd1;

  // Effect slot lookup.
  logic          id_ok;
  logic [EW-1:0] id_idx;
  logic          id_active;
  assign id_ok     = (effect_id < SLOTS);
  assign id_idx    = effect_id[EW-1:0];
  assign id_active = effect_mask[id_idx];

  // Frame end arithmetic.
  logic [15:0]   load_delta;
  logic [SW-1:0] sample_inc;
  assign load_delta = (cpu_load >= previous_load) ? (cpu_load - previous_load)
                                                  : (previous_load - cpu_load);
  assign sample_inc = sample_cnt + SW'(1);

  // Memory write port: the clearing sweep or the span write-back.
  always_comb begin
    mem_we    = (state == ST_CLEAR) || pipe_vld;
    mem_waddr = (state == ST_CLEAR) ? walk_addr : pipe_addr;
    mem_wdata = (state == ST_CLEAR) ? '0 : wb_count;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= line_mem[walk_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget_threshold <= BUDGET_RESET;
      window_target    <= WINDOW_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BUDGET_THRESHOLD: budget_threshold <= wr_data;
        REG_WINDOW_TARGET:    window_target    <= wr_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      walk_addr         <= '0;
      span_end          <= '0;
      clear_report      <= 1'b0;
      pipe_vld          <= 1'b0;
      pipe_addr         <= '0;
      done              <= 1'b0;
      effect_mask       <= '0;
      effect_count      <= '0;
      effect_count_peak <= '0;
      frame_peak        <= '0;
      line_peak_max     <= '0;
      frame_counter     <= '0;
      sample_cnt        <= '0;
      window_flag       <= 1'b0;
      load_total        <= '0;
      load_peak         <= '0;
      previous_load     <= '0;
      jitter_peak       <= '0;
      over_budget_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_FRAME_BEGIN: begin
                frame_peak   <= '0;
                walk_addr    <= '0;
                clear_report <= 1'b1;
                state        <= ST_CLEAR;
              end
              OP_SPRITE_SPAN: begin
                if (span_none) begin
                  done <= 1'b1;
                end else begin
                  walk_addr <= first_s[AW-1:0];
                  span_end  <= last_m1[AW-1:0];
                  state     <= ST_SPAN;
                end
              end
              OP_FRAME_END: begin
                frame_counter <= frame_counter + 16'd1;
                if (sample_cnt < SAMPLE_CAP) begin
                  sample_cnt <= sample_inc;
                  if (sample_inc >= SW'(window_target)) begin
                    window_flag <= 1'b1;
                  end
                end
                load_total <= load_total + {16'd0, cpu_load};
                if (cpu_load > load_peak) begin
                  load_peak <= cpu_load;
                end
                if (load_delta > jitter_peak) begin
                  jitter_peak <= load_delta;
                end
                if (cpu_load > budget_threshold) begin
                  over_budget_count <= over_budget_count + 16'd1;
                end
                if (frame_peak > line_peak_max) begin
                  line_peak_max <= frame_peak;
                end
                previous_load <= cpu_load;
                done          <= 1'b1;
              end
              OP_EFFECT_START: begin
                if (id_ok && !id_active) begin
                  effect_mask[id_idx] <= 1'b1;
                  effect_count        <= effect_count + 7'd1;
                  if ((effect_count + 7'd1) > effect_count_peak) begin
                    effect_count_peak <= effect_count + 7'd1;
                  end
                end
                done <= 1'b1;
              end
              OP_EFFECT_END: begin
                if (id_ok && id_active) begin
                  effect_mask[id_idx] <= 1'b0;
                  if (effect_count != 7'd0) begin
                    effect_count <= effect_count - 7'd1;
                  end
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (walk_addr == LAST_LINE) begin
            done         <= clear_report;
            clear_report <= 1'b0;
            state        <= ST_IDLE;
          end else begin
            walk_addr <= walk_addr + AW'(1);
          end
        end
        ST_SPAN: begin
          pipe_vld  <= 1'b1;
          pipe_addr <= walk_addr;
          if (pipe_vld && (wb_count > frame_peak)) begin
            frame_peak <= wb_count;
          end
          if (walk_addr == span_end) begin
            state <= ST_DRAIN;
          end else begin
            walk_addr <= walk_addr + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (wb_count > frame_peak) begin
            frame_peak <= wb_count;
          end
          pipe_vld <= 1'b0;
          done     <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result ports show the statistics directly.
  assign active_effects     = effect_count;
  assign effect_peak        = effect_count_peak;
  assign frame_line_peak    = frame_peak;
  assign max_line_occupancy = line_peak_max;
  assign frames_seen        = frame_counter;
  assign samples_recorded   = sample_cnt[SAMPLE_W-1:0];
  assign window_complete    = window_flag;
  assign load_sum           = load_total;
  assign load_max           = load_peak;
  assign jitter_max         = jitter_peak;
  assign over_budget_frames = over_budget_count;

  // A frame begin always starts the clearing sweep.
  a_frame_begin_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_FRAME_BEGIN)) |=> (state == ST_CLEAR))
    else $error("frame begin did not start the clearing sweep");

  // The write-back stage is only live while a span is being walked.
  a_pipe_in_span: assert property (@(posedge clk) disable iff (rst)
    pipe_vld |-> ((state == ST_SPAN) || (state == ST_DRAIN)))
    else $error("line write-back outside a span walk");

  // The live effect count never exceeds its recorded peak.
  a_effect_peak: assert property (@(posedge clk) disable iff (rst)
    effect_count <= effect_count_peak)
    else $error("effect count above its peak");

  // The sample counter stops at capacity.
  a_sample_cap: assert property (@(posedge clk) disable iff (rst)
    sample_cnt <= SAMPLE_CAP)
    else $error("sample count beyond capacity");

  // A result is only reported as the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while the sequencer is busy");

endmodule : frame_performance_monitor_top
`default_nettype wire
